>>> hw/rtl/asvm_pkg.sv
// ----------------------------------------------------------------------------
// asvm_pkg: shared types and constants for the ADC scan voltage monitor
// Channel codes, register indexes, field widths and scaling constants.
// ----------------------------------------------------------------------------
package asvm_pkg;

  // default parameter values
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF   = 6;

  // port widths
  localparam int IN_SAMPLE_W = 10;
  localparam int THRESH_W    = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;
  localparam int CHAN_W      = 2;
  localparam int VOLTS_W     = 5;
  localparam int HUND_W      = 7;

  typedef logic [CHAN_W-1:0]    chan_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // channels of the scan rotation
  localparam chan_t CH_THROTTLE = 2'd0;
  localparam chan_t CH_CAP1     = 2'd1;
  localparam chan_t CH_SUPPLY   = 2'd2;

  // configuration register indexes
  localparam cfg_idx_t REG_SERIES_MODE = 1'd0;
  localparam cfg_idx_t REG_THRESHOLD   = 1'd1;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd400;

  // 16 V full scale: sample scaled by 2^4 before the divide by full count
  localparam int FS_SHIFT = 4;

  // supply scaling: 391 / 12500 per count, divisor split as 4 * 3125
  localparam int SERIES_MUL      = 391;
  localparam int SERIES_MUL_W    = 9;
  localparam int SERIES_DIV      = 12500;
  localparam int SERIES_PRESHIFT = 2;
  localparam int SERIES_DIV_ODD  = SERIES_DIV / (1 << SERIES_PRESHIFT);
  localparam int SERIES_DIV_W    = 11;   // 2^11 < 3125

  localparam int HUNDRED  = 100;
  localparam int VOLTS_SAT = 31;
  localparam int HUND_SAT  = 99;

endpackage

>>> hw/rtl/adc_scan_voltage_monitor.sv
// ----------------------------------------------------------------------------
// adc_scan_voltage_monitor: capacitor and supply voltage readout from ADC scan
//
// Samples arrive on the in_ channel in a fixed rotation: throttle, capacitor
// one, supply. Each transfer gives one result transfer on the out_ channel
// with the channel the sample belonged to and the throttle-over flag. On a
// supply sample the result also carries capacitor one and capacitor two in
// volts and hundredths (volts_valid set); otherwise those fields are zero.
// Registers are written on the cfg_ channel; cfg_ready is always high. The
// user must write them only while the block is idle; it is not enforced.
//
// Throughput: one sample per cycle unless out_stall holds the pipe. The depth
// is set by the supply scaling: constant multiply, reciprocal multiply,
// quotient correction, hundredths conversion and the capacitor two
// subtraction each own a stage. When a result sits on the outputs and
// out_stall is high, the whole pipe holds and in_stall rises in the same
// cycle. Reset empties the pipe, starts the rotation at the throttle channel,
// clears the stored samples, sets series_mode to 0 and the threshold to 400.
// ----------------------------------------------------------------------------
module adc_scan_voltage_monitor
  import asvm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // sample channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [IN_SAMPLE_W-1:0] in_sample,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CHAN_W-1:0]      out_sampled_channel,
  output logic                   out_throttle_over,
  output logic                   out_volts_valid,
  output logic [VOLTS_W-1:0]     out_cap1_volts,
  output logic [HUND_W-1:0]      out_cap1_hundredths,
  output logic [VOLTS_W-1:0]     out_cap2_volts,
  output logic [HUND_W-1:0]      out_cap2_hundredths,
  output logic                   out_cap2_clamped,
  // configuration
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int N    = SAMPLE_BITS;
  localparam int F    = FRAC_BITS;
  localparam int K    = F + FS_SHIFT;
  localparam int XW   = N + K;
  // full-scale divide
  localparam logic [XW:0] DIV_D1 = (XW+1)'((1 << N) - 1);
  localparam logic [XW:0] DIV_D2 = (XW+1)'(2 * ((1 << N) - 1));
  // supply scaling
  localparam int YW_FULL = N + F + SERIES_MUL_W;
  localparam int YW      = YW_FULL - SERIES_PRESHIFT;
  localparam int MW      = YW - SERIES_DIV_W;
  localparam logic [MW-1:0] RECIP = MW'((64'd1 << YW) / SERIES_DIV_ODD);
  localparam int PW      = YW + MW;
  // whole volts widths
  localparam int SW   = MW - F;
  localparam int CW   = ((SW > VOLTS_W) ? SW : VOLTS_W) + 1;
  localparam int CMPW = (N > THRESH_W) ? N : THRESH_W;

  // s * 2^K / (2^N - 1): shift-add estimate, low by at most two, then fix up
  function automatic logic [K:0] scale_fx(input logic [N-1:0] s);
    logic [XW-1:0] x;
    logic [XW:0]   sum;
    logic [K:0]    q0;
    logic [XW:0]   r;
    x   = {s, {K{1'b0}}};
    sum = {1'b0, x} + (XW+1)'(x >> N);
    q0  = sum[XW:N];
    r   = {1'b0, x} - {q0, {N{1'b0}}} + (XW+1)'(q0);
    return q0 + (K+1)'(r >= DIV_D1) + (K+1)'(r >= DIV_D2);
  endfunction

  // fractional bits to hundredths, truncated
  function automatic logic [HUND_W-1:0] frac_hund(input logic [F-1:0] fr);
    logic [F+6:0] p;
    p = (F+7)'(fr) * (F+7)'(HUNDRED);
    return HUND_W'(p >> F);
  endfunction

  // --------------------------------------------------------------------------
  // configuration and scan state
  // --------------------------------------------------------------------------
  logic                series_mode_r;
  logic [THRESH_W-1:0] threshold_r;
  chan_t               ch_idx_r;
  logic [N-1:0]        throttle_r;
  logic [N-1:0]        cap1_r;

  logic   adv;
  logic   in_accept;
  chan_t  ch_cur;
  chan_t  ch_idx_nxt;
  logic [N-1:0] samp;
  logic [N-1:0] thr_cur;
  logic         over_nxt;

  assign cfg_ready = 1'b1;
  // the pipe moves unless a result is held by the receiver
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign in_accept = in_valid && adv;
  assign samp      = N'(in_sample);

  always_comb begin
    case (ch_idx_r)
      CH_CAP1: begin
        ch_cur     = CH_CAP1;
        ch_idx_nxt = CH_SUPPLY;
      end
      CH_SUPPLY: begin
        ch_cur     = CH_SUPPLY;
        ch_idx_nxt = CH_THROTTLE;
      end
      default: begin
        ch_cur     = CH_THROTTLE;
        ch_idx_nxt = CH_CAP1;
      end
    endcase
  end

  assign thr_cur  = (ch_cur == CH_THROTTLE) ? samp : throttle_r;
  assign over_nxt = CMPW'(thr_cur) > CMPW'(threshold_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_mode_r <= 1'b0;
      threshold_r   <= THRESH_RESET;
      ch_idx_r      <= CH_THROTTLE;
      throttle_r    <= '0;
      cap1_r        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SERIES_MODE: series_mode_r <= cfg_data[0];
          REG_THRESHOLD:   threshold_r   <= THRESH_W'(cfg_data);
          default: ;
        endcase
      end
      if (in_accept) begin
        ch_idx_r <= ch_idx_nxt;
        if (ch_cur == CH_THROTTLE) throttle_r <= samp;
        if (ch_cur == CH_CAP1)     cap1_r     <= samp;
      end
    end
  end

  // --------------------------------------------------------------------------
  // pipeline registers
  // --------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r;
  logic out_valid_r;

  // stage 1: captured sample
  chan_t        s1_ch_r;
  logic         s1_over_r, s1_mode_r;
  logic [N-1:0] s1_samp_r, s1_cap1_r;
  // stage 2: full-scale quotients and supply product
  chan_t        s2_ch_r;
  logic         s2_over_r, s2_mode_r;
  logic [K:0]   s2_fx1_r, s2_fxp_r;
  logic [YW-1:0] s2_yq_r;
  // stage 3: reciprocal product
  chan_t        s3_ch_r;
  logic         s3_over_r, s3_mode_r;
  logic [K:0]   s3_fx1_r, s3_fxp_r;
  logic [YW-1:0] s3_yq_r;
  logic [PW-1:0] s3_prod_r;
  // stage 4: corrected supply quotient
  chan_t        s4_ch_r;
  logic         s4_over_r, s4_mode_r;
  logic [K:0]   s4_fx1_r, s4_fxp_r;
  logic [MW-1:0] s4_fxs_r;
  // stage 5: volts and hundredths
  chan_t        s5_ch_r;
  logic         s5_over_r, s5_mode_r;
  logic [VOLTS_W-1:0] s5_v1_r, s5_vp_r;
  logic [HUND_W-1:0]  s5_h1_r, s5_hp_r, s5_hs_r;
  logic [SW-1:0]      s5_vs_r;
  // output
  chan_t              out_ch_r;
  logic               out_over_r, out_vv_r, out_clamp_r;
  logic [VOLTS_W-1:0] out_v1_r, out_v2_r;
  logic [HUND_W-1:0]  out_h1_r, out_h2_r;

  // stage 2 logic
  logic [YW_FULL-1:0] y_nxt;
  logic [YW-1:0]      yq_nxt;
  assign y_nxt  = YW_FULL'({s1_samp_r, {F{1'b0}}}) * YW_FULL'(SERIES_MUL);
  assign yq_nxt = y_nxt[YW_FULL-1:SERIES_PRESHIFT];

  // stage 3 logic
  logic [PW-1:0] prod_nxt;
  assign prod_nxt = PW'(s2_yq_r) * PW'(RECIP);

  // stage 4 logic: estimate is low by at most one
  logic [MW-1:0] q0;
  logic [YW-1:0] rem;
  logic [MW-1:0] fxs_nxt;
  assign q0      = s3_prod_r[PW-1:YW];
  assign rem     = s3_yq_r - YW'(YW'(q0) * YW'(SERIES_DIV_ODD));
  assign fxs_nxt = q0 + MW'(rem >= YW'(SERIES_DIV_ODD));

  // output stage logic: capacitor two
  logic [CW-1:0]     vs_e, v1_e, dv;
  logic              borrow, neg, sat;
  logic [HUND_W:0]   dh_w;
  logic [VOLTS_W-1:0] v2_nxt;
  logic [HUND_W-1:0]  h2_nxt, h1_nxt;
  logic [VOLTS_W-1:0] v1_nxt;
  logic               clamp_nxt, vv_nxt;

  assign vs_e   = CW'(s5_vs_r);
  assign v1_e   = CW'(s5_v1_r);
  // borrow only when the supply hundredths are strictly below
  assign borrow = s5_hs_r < s5_h1_r;
  assign neg    = (vs_e < v1_e) || ((vs_e == v1_e) && borrow);
  assign dv     = vs_e - v1_e - CW'(borrow);
  assign dh_w   = borrow ? ((HUND_W+1)'(s5_hs_r) + (HUND_W+1)'(HUNDRED)
                            - (HUND_W+1)'(s5_h1_r))
                         : ((HUND_W+1)'(s5_hs_r) - (HUND_W+1)'(s5_h1_r));
  assign sat    = dv > CW'(VOLTS_SAT);

  always_comb begin
    vv_nxt    = (s5_ch_r == CH_SUPPLY);
    clamp_nxt = 1'b0;
    v1_nxt    = '0;
    h1_nxt    = '0;
    v2_nxt    = '0;
    h2_nxt    = '0;
    if (vv_nxt) begin
      v1_nxt = s5_v1_r;
      h1_nxt = s5_h1_r;
      if (!s5_mode_r) begin
        v2_nxt = s5_vp_r;
        h2_nxt = s5_hp_r;
      end else if (neg) begin
        clamp_nxt = 1'b1;
      end else if (sat) begin
        v2_nxt = VOLTS_W'(VOLTS_SAT);
        h2_nxt = HUND_W'(HUND_SAT);
      end else begin
        v2_nxt = dv[VOLTS_W-1:0];
        h2_nxt = dh_w[HUND_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_accept;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      out_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ch_r   <= ch_cur;
      s1_over_r <= over_nxt;
      s1_mode_r <= series_mode_r;
      s1_samp_r <= samp;
      s1_cap1_r <= cap1_r;

      s2_ch_r   <= s1_ch_r;
      s2_over_r <= s1_over_r;
      s2_mode_r <= s1_mode_r;
      s2_fx1_r  <= scale_fx(s1_cap1_r);
      s2_fxp_r  <= scale_fx(s1_samp_r);
      s2_yq_r   <= yq_nxt;

      s3_ch_r   <= s2_ch_r;
      s3_over_r <= s2_over_r;
      s3_mode_r <= s2_mode_r;
      s3_fx1_r  <= s2_fx1_r;
      s3_fxp_r  <= s2_fxp_r;
      s3_yq_r   <= s2_yq_r;
      s3_prod_r <= prod_nxt;

      s4_ch_r   <= s3_ch_r;
      s4_over_r <= s3_over_r;
      s4_mode_r <= s3_mode_r;
      s4_fx1_r  <= s3_fx1_r;
      s4_fxp_r  <= s3_fxp_r;
      s4_fxs_r  <= fxs_nxt;

      s5_ch_r   <= s4_ch_r;
      s5_over_r <= s4_over_r;
      s5_mode_r <= s4_mode_r;
      s5_v1_r   <= s4_fx1_r[K:F];
      s5_h1_r   <= frac_hund(s4_fx1_r[F-1:0]);
      s5_vp_r   <= s4_fxp_r[K:F];
      s5_hp_r   <= frac_hund(s4_fxp_r[F-1:0]);
      s5_vs_r   <= s4_fxs_r[MW-1:F];
      s5_hs_r   <= frac_hund(s4_fxs_r[F-1:0]);

      out_ch_r    <= s5_ch_r;
      out_over_r  <= s5_over_r;
      out_vv_r    <= vv_nxt;
      out_v1_r    <= v1_nxt;
      out_h1_r    <= h1_nxt;
      out_v2_r    <= v2_nxt;
      out_h2_r    <= h2_nxt;
      out_clamp_r <= clamp_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sampled_channel = out_ch_r;
  assign out_throttle_over   = out_over_r;
  assign out_volts_valid     = out_vv_r;
  assign out_cap1_volts      = out_v1_r;
  assign out_cap1_hundredths = out_h1_r;
  assign out_cap2_volts      = out_v2_r;
  assign out_cap2_hundredths = out_h2_r;
  assign out_cap2_clamped    = out_clamp_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_volts_on_supply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_volts_valid) |-> (out_sampled_channel == CH_SUPPLY))
    else $error("voltage fields on a non-supply result");

  a_clamp_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_cap2_clamped) |->
      (out_volts_valid && out_cap2_volts == '0 && out_cap2_hundredths == '0))
    else $error("clamped capacitor two is not zero");

  a_hund_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cap1_hundredths < HUND_W'(HUNDRED) &&
                   out_cap2_hundredths < HUND_W'(HUNDRED)))
    else $error("hundredths out of range");

  a_rotation: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && ch_idx_r == CH_CAP1) |=> (ch_idx_r == CH_SUPPLY))
    else $error("rotation did not advance to supply");

endmodule

>>> dv/tb_adc_scan_voltage_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adc_scan_voltage_monitor: self-checking bench for the ADC scan monitor
// Drives samples through the throttle / capacitor one / supply rotation under
// bursty input, random output stalls and several register settings, and
// checks every result against a scoreboard that tracks the rotation and
// converts capacitor and supply readings to volts and hundredths.
// ----------------------------------------------------------------------------
module tb_adc_scan_voltage_monitor;
  import asvm_pkg::*;

  localparam int          FRAC       = FRAC_BITS_DEF;
  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_BITS_DEF) - 1;
  localparam int unsigned HUND_CAP   = VOLTS_SAT * HUNDRED + HUND_SAT;

  typedef struct packed {
    chan_t              chan;
    logic               over;
    logic               volts_ok;
    logic [VOLTS_W-1:0] c1_volts;
    logic [HUND_W-1:0]  c1_hund;
    logic [VOLTS_W-1:0] c2_volts;
    logic [HUND_W-1:0]  c2_hund;
    logic               clamped;
  } monitor_result_t;

  class voltage_scoreboard;
    bit                    series;
    logic [THRESH_W-1:0]   thresh;
    chan_t                 next_chan;
    logic [IN_SAMPLE_W-1:0] thr_s;
    logic [IN_SAMPLE_W-1:0] cap1_s;
    monitor_result_t       expected_q[$];
    int                    mismatches;

    function new();
      series     = 1'b0;
      thresh     = THRESH_RESET;
      next_chan  = CH_THROTTLE;
      thr_s      = '0;
      cap1_s     = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
      if (idx == REG_SERIES_MODE) series = d[0];
      else thresh = d[THRESH_W-1:0];
    endfunction

    function int unsigned fx_to_hund(int unsigned fx);
      return (fx >> FRAC) * HUNDRED + (((fx & ((1 << FRAC) - 1)) * HUNDRED) >> FRAC);
    endfunction

    // 16 V full scale
    function int unsigned scaled16(logic [IN_SAMPLE_W-1:0] s);
      return fx_to_hund((int'(s) << (FRAC + FS_SHIFT)) / SAMPLE_MAX);
    endfunction

    // supply in series mode, 391/12500 V per count
    function int unsigned supply_hund(logic [IN_SAMPLE_W-1:0] s);
      return fx_to_hund(((int'(s) << FRAC) * SERIES_MUL) / SERIES_DIV);
    endfunction

    function void note_input(logic [IN_SAMPLE_W-1:0] s);
      monitor_result_t e;
      int unsigned     c1;
      int unsigned     c2;
      int unsigned     vcc;
      e = '0;
      case (next_chan)
        CH_CAP1: begin
          cap1_s    = s;
          e.chan    = CH_CAP1;
          next_chan = CH_SUPPLY;
        end
        CH_SUPPLY: begin
          c1 = scaled16(cap1_s);
          if (series) begin
            vcc = supply_hund(s);
            if (vcc >= c1) begin
              c2 = vcc - c1;
            end else begin
              c2        = 0;
              e.clamped = 1'b1;
            end
          end else begin
            c2 = scaled16(s);
          end
          if (c2 > HUND_CAP) c2 = HUND_CAP;
          e.chan     = CH_SUPPLY;
          e.volts_ok = 1'b1;
          e.c1_volts = VOLTS_W'(c1 / HUNDRED);
          e.c1_hund  = HUND_W'(c1 % HUNDRED);
          e.c2_volts = VOLTS_W'(c2 / HUNDRED);
          e.c2_hund  = HUND_W'(c2 % HUNDRED);
          next_chan  = CH_THROTTLE;
        end
        default: begin
          // index three is never reached; treat it as throttle
          thr_s     = s;
          e.chan    = CH_THROTTLE;
          next_chan = CH_CAP1;
        end
      endcase
      e.over = (thr_s > thresh);
      expected_q.push_back(e);
    endfunction

    function void check_result(monitor_result_t got);
      monitor_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: chan=%0d over=%0b", got.chan, got.over);
        return;
      end
      e = expected_q.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp chan=%0d over=%0b vv=%0b c1=%0d.%0d c2=%0d.%0d clamp=%0b",
                   e.chan, e.over, e.volts_ok, e.c1_volts, e.c1_hund, e.c2_volts,
                   e.c2_hund, e.clamped);
          $display("         got chan=%0d over=%0b vv=%0b c1=%0d.%0d c2=%0d.%0d clamp=%0b",
                   got.chan, got.over, got.volts_ok, got.c1_volts, got.c1_hund,
                   got.c2_volts, got.c2_hund, got.clamped);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [IN_SAMPLE_W-1:0] in_sample;
  logic                   out_valid;
  logic                   out_stall;
  logic [CHAN_W-1:0]      out_sampled_channel;
  logic                   out_throttle_over;
  logic                   out_volts_valid;
  logic [VOLTS_W-1:0]     out_cap1_volts;
  logic [HUND_W-1:0]      out_cap1_hundredths;
  logic [VOLTS_W-1:0]     out_cap2_volts;
  logic [HUND_W-1:0]      out_cap2_hundredths;
  logic                   out_cap2_clamped;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  voltage_scoreboard sb;
  bit                hold_req;

  adc_scan_voltage_monitor i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sampled_channel (out_sampled_channel),
    .out_throttle_over   (out_throttle_over),
    .out_volts_valid     (out_volts_valid),
    .out_cap1_volts      (out_cap1_volts),
    .out_cap1_hundredths (out_cap1_hundredths),
    .out_cap2_volts      (out_cap2_volts),
    .out_cap2_hundredths (out_cap2_hundredths),
    .out_cap2_clamped    (out_cap2_clamped),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("adc_scan_voltage_monitor test failed");
    $finish;
  end

  // receiver: stall pattern drawn at random from four modes, long hold-off on request
  initial begin
    int mode;
    int cyc;
    int hold_left;
    bit hold_seen;
    out_stall = 1'b0;
    mode      = 0;
    cyc       = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 50 == 0) mode = $urandom_range(0, 3);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (cyc % 5 < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_sampled_channel, out_throttle_over, out_volts_valid,
                        out_cap1_volts, out_cap1_hundredths, out_cap2_volts,
                        out_cap2_hundredths, out_cap2_clamped});
  end

  task automatic send_sample(input logic [IN_SAMPLE_W-1:0] v);
    @(negedge clk);
    in_valid  <= 1'b1;
    in_sample <= v;
    do @(posedge clk); while (in_stall);
    sb.note_input(v);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid  <= 1'b0;
      in_sample <= IN_SAMPLE_W'($urandom);
    end
  endtask

  // hold the sender off until every expected result has come
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [IN_SAMPLE_W-1:0] s;
    logic [IN_SAMPLE_W-1:0] eq_supply;
    int unsigned            c1;
    int unsigned            vcc;
    int                     burst_left;
    int                     t;
    int                     r;
    bit                     ser;

    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    hold_req  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: parallel mode at reset settings
    send_sample(10'd0);    send_sample(10'd0);    send_sample(10'd0);
    send_sample(10'd1023); send_sample(10'd1023); send_sample(10'd1023);
    // throttle equal to threshold does not raise the flag, one above does
    send_sample(10'd400);  send_sample(10'd512);  send_sample(10'd1);
    send_sample(10'd401);  send_sample(10'd1);    send_sample(10'd1022);
    drain();

    write_reg(REG_SERIES_MODE, 10'h3FF);
    write_reg(REG_THRESHOLD, 10'd0);
    send_sample(10'd0);    send_sample(10'd1023); send_sample(10'd1023);
    // supply below capacitor one: clamp to zero
    send_sample(10'd1023); send_sample(10'd1023); send_sample(10'd0);
    // pick a supply whose hundredths match capacitor one: no borrow
    c1        = sb.scaled16(10'd512);
    eq_supply = 10'd1023;
    for (int i = 0; i <= SAMPLE_MAX; i++) begin
      vcc = sb.supply_hund(i[IN_SAMPLE_W-1:0]);
      if (vcc >= c1 && vcc % HUNDRED == c1 % HUNDRED) begin
        eq_supply = i[IN_SAMPLE_W-1:0];
        break;
      end
    end
    send_sample(10'd1);    send_sample(10'd512);  send_sample(eq_supply);
    send_sample(10'd0);    send_sample(10'd0);    send_sample(10'd1023);
    drain();

    write_reg(REG_THRESHOLD, 10'd1023);
    send_sample(10'd1023); send_sample(10'd1023); send_sample(10'd100);
    drain();

    // random phases, each with its own register setting
    for (int p = 0; p < 8; p++) begin
      ser = (p % 2 == 1);
      if (p >= 4) ser = $urandom_range(0, 1);
      if ($urandom_range(0, 1)) begin
        write_reg(REG_SERIES_MODE, {9'($urandom_range(0, 511)), ser});
        write_reg(REG_THRESHOLD, (p == 0) ? 10'd0 : (p == 1) ? 10'd1023 :
                                 10'($urandom_range(0, 1023)));
      end else begin
        write_reg(REG_THRESHOLD, (p == 0) ? 10'd0 : (p == 1) ? 10'd1023 :
                                 10'($urandom_range(0, 1023)));
        write_reg(REG_SERIES_MODE, {9'($urandom_range(0, 511)), ser});
      end

      if (p == 3) begin
        // fill the pipe against a long receiver hold-off
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++) send_sample(IN_SAMPLE_W'($urandom));
      end

      burst_left = 0;
      for (int k = 0; k < 85; k++) begin
        if (burst_left == 0) begin
          idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        if (p == 5 && k == 50) drain();
        r = $urandom_range(0, 9);
        if (r == 0) begin
          s = 10'd0;
        end else if (r == 1) begin
          s = 10'd1023;
        end else if (r <= 3 && sb.next_chan == CH_THROTTLE) begin
          // land near the threshold
          t = int'(sb.thresh) + $urandom_range(0, 4) - 2;
          if (t < 0) t = 0;
          if (t > int'(SAMPLE_MAX)) t = SAMPLE_MAX;
          s = t[IN_SAMPLE_W-1:0];
        end else begin
          s = IN_SAMPLE_W'($urandom_range(0, 1023));
        end
        send_sample(s);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("adc_scan_voltage_monitor test passed");
    end else begin
      $display("adc_scan_voltage_monitor test failed");
    end
    $finish;
  end

endmodule
